@@ rtl/ucmf_pkg.sv @@
// shared types and constants for the unit capacity max flow block
`default_nettype none
package ucmf_pkg;
  localparam int unsigned NODES  = 128;
  localparam int unsigned NODE_W = 7;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned FLOW_W = 7;

  localparam logic [1:0] KIND_EDGE    = 2'd0;
  localparam logic [1:0] KIND_CLEAR   = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  typedef struct packed {
    logic              cap_we;
    logic              cap_clr;
    logic [NODE_W-1:0] cap_row;
    logic [NODE_W-1:0] cap_col;
    logic              cap_bit;
    logic              flow_we;
    logic              flow_clr;
    logic [NODE_W-1:0] flow_row;
    logic [NODE_W-1:0] flow_col;
    logic              flow_bit;
    logic [NODE_W-1:0] rd_row;
    logic [NODE_W-1:0] rd_col;
  } mem_cmd_t;

  typedef struct packed {
    logic cap;
    logic flow;
    logic flow_back;
  } mem_rd_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [POS_W-1:0]  pos;
    logic              phase;
    logic              dir;
  } stk_t;
endpackage
`default_nettype wire

@@ rtl/unit_capacity_max_flow.sv @@
// top level: sequencer for depth-first augmenting searches over a 0/1 matrix
// An edge write (kind 0) is taken straight from idle and busy_o stays low,
// so edge words can be loaded every cycle. A clear (kind 1) sweeps the
// matrix one row a cycle with busy_o high. After reset the same sweep runs
// before the first word is accepted. A compute (kind 2) first clears the
// flow matrices row by row, then runs searches: a candidate that is already
// visited is skipped in the check state alone, any other candidate test
// reads the matrix, then evaluates; a pop reads the stack, then loads the top;
// an augmentation saves the top, walks the stack writing one flow bit per
// path edge, then restarts the search. The result is valid on max_flow_o
// while done_o is high for exactly one cycle, in the cycle after the last
// search fails; the receiver cannot stall it. Other kinds are ignored.
`default_nettype none
module unit_capacity_max_flow (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    kind_i,
  input  logic [ucmf_pkg::NODE_W-1:0]   from_node_i,
  input  logic [ucmf_pkg::NODE_W-1:0]   to_node_i,
  input  logic                          edge_present_i,
  input  logic                          sink_index_we_i,
  input  logic [ucmf_pkg::NODE_W-1:0]   sink_index_i,
  output logic                          done_o,
  output logic [ucmf_pkg::FLOW_W-1:0]   max_flow_o
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLRCAP = 4'd1;
  localparam logic [3:0] S_CLRFLW = 4'd2;
  localparam logic [3:0] S_INIT   = 4'd3;
  localparam logic [3:0] S_CHK    = 4'd4;
  localparam logic [3:0] S_EVAL   = 4'd5;
  localparam logic [3:0] S_POP    = 4'd6;
  localparam logic [3:0] S_SAVE   = 4'd7;
  localparam logic [3:0] S_WLOAD  = 4'd8;
  localparam logic [3:0] S_WSTEP  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  localparam logic [ucmf_pkg::NODE_W-1:0] LAST_ROW = ucmf_pkg::NODE_W'(ucmf_pkg::NODES - 1);
  localparam logic [ucmf_pkg::POS_W-1:0]  FULL     = ucmf_pkg::POS_W'(ucmf_pkg::NODES);
  localparam logic [ucmf_pkg::FLOW_W-1:0] FLOW_MAX = '1;

  logic [3:0] state_q, state_d;
  logic [ucmf_pkg::NODE_W-1:0] sink_q, sink_d;
  logic [ucmf_pkg::NODE_W-1:0] row_q, row_d;
  logic [ucmf_pkg::NODES-1:0]  vis_q, vis_d;
  logic [ucmf_pkg::POS_W-1:0]  depth_q, depth_d;
  logic [ucmf_pkg::POS_W-1:0]  k_q, k_d;
  logic [ucmf_pkg::FLOW_W-1:0] total_q, total_d;
  ucmf_pkg::stk_t top_q, top_d, prev_q, prev_d;

  ucmf_pkg::mem_cmd_t cmd;
  ucmf_pkg::mem_rd_t  rd;
  logic               stk_we;
  logic [ucmf_pkg::NODE_W-1:0] stk_waddr, stk_raddr;
  ucmf_pkg::stk_t     stk_wdata, stk_rdata;

  ucmf_edge_mem u_mem (.clk_i(clk_i), .cmd_i(cmd), .rd_o(rd));

  ucmf_stack u_stk (
    .clk_i(clk_i), .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  logic [ucmf_pkg::NODE_W-1:0] cur_i;
  assign cur_i = top_q.pos[ucmf_pkg::NODE_W-1:0];

  always_comb begin
    state_d = state_q;
    sink_d  = sink_index_we_i ? sink_index_i : sink_q;
    row_d   = row_q;
    vis_d   = vis_q;
    depth_d = depth_q;
    k_d     = k_q;
    total_d = total_q;
    top_d   = top_q;
    prev_d  = prev_q;
    cmd     = '0;
    cmd.rd_row = top_q.node;
    cmd.rd_col = cur_i;
    stk_we    = 1'b0;
    stk_waddr = depth_q[ucmf_pkg::NODE_W-1:0] - ucmf_pkg::NODE_W'(1);
    stk_wdata = top_q;
    stk_raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (kind_i)
            ucmf_pkg::KIND_EDGE: begin
              cmd.cap_we  = 1'b1;
              cmd.cap_row = from_node_i;
              cmd.cap_col = to_node_i;
              cmd.cap_bit = edge_present_i;
            end
            ucmf_pkg::KIND_CLEAR: begin
              row_d   = '0;
              state_d = S_CLRCAP;
            end
            ucmf_pkg::KIND_COMPUTE: begin
              row_d   = '0;
              total_d = '0;
              state_d = S_CLRFLW;
            end
            default: ;
          endcase
        end
      end
      S_CLRCAP: begin
        cmd.cap_clr = 1'b1;
        cmd.cap_row = row_q;
        row_d = row_q + ucmf_pkg::NODE_W'(1);
        if (row_q == LAST_ROW) state_d = S_IDLE;
      end
      S_CLRFLW: begin
        cmd.flow_clr = 1'b1;
        cmd.flow_row = row_q;
        row_d = row_q + ucmf_pkg::NODE_W'(1);
        if (row_q == LAST_ROW) state_d = (sink_q == '0) ? S_DONE : S_INIT;
      end
      S_INIT: begin
        vis_d    = '0;
        vis_d[0] = 1'b1;
        depth_d  = ucmf_pkg::POS_W'(1);
        top_d    = '0;
        state_d  = S_CHK;
      end
      S_CHK: begin
        if (top_q.node == sink_q) begin
          state_d = S_SAVE;
        end else if (top_q.pos > {1'b0, sink_q}) begin
          if (depth_q == ucmf_pkg::POS_W'(1)) begin
            state_d = S_DONE;
          end else begin
            depth_d   = depth_q - ucmf_pkg::POS_W'(1);
            stk_raddr = depth_q[ucmf_pkg::NODE_W-1:0] - ucmf_pkg::NODE_W'(2);
            state_d   = S_POP;
          end
        end else if (!top_q.phase && vis_q[cur_i]) begin
          top_d.pos = top_q.pos + ucmf_pkg::POS_W'(1);
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_CHK;
        if (!top_q.phase) begin
          top_d.phase = 1'b1;
          if (rd.cap && !rd.flow) begin
            vis_d[cur_i] = 1'b1;
            top_d.dir = 1'b0;
            if (depth_q < FULL) begin
              stk_we    = 1'b1;
              stk_wdata = top_d;
              top_d     = '0;
              top_d.node = cur_i;
              depth_d   = depth_q + ucmf_pkg::POS_W'(1);
            end
          end
        end else begin
          top_d.phase = 1'b0;
          top_d.pos   = top_q.pos + ucmf_pkg::POS_W'(1);
          if (rd.flow_back) begin
            vis_d[cur_i] = 1'b1;
            top_d.dir = 1'b1;
            if (depth_q < FULL) begin
              stk_we    = 1'b1;
              stk_wdata = top_d;
              top_d     = '0;
              top_d.node = cur_i;
              depth_d   = depth_q + ucmf_pkg::POS_W'(1);
            end
          end
        end
      end
      S_POP: begin
        top_d   = stk_rdata;
        state_d = S_CHK;
      end
      S_SAVE: begin
        stk_we    = 1'b1;
        stk_raddr = '0;
        state_d   = S_WLOAD;
      end
      S_WLOAD: begin
        prev_d    = stk_rdata;
        stk_raddr = ucmf_pkg::NODE_W'(1);
        k_d       = ucmf_pkg::POS_W'(1);
        state_d   = S_WSTEP;
      end
      S_WSTEP: begin
        cmd.flow_we = 1'b1;
        if (!prev_q.dir) begin
          cmd.flow_row = prev_q.node;
          cmd.flow_col = stk_rdata.node;
          cmd.flow_bit = 1'b1;
        end else begin
          cmd.flow_row = stk_rdata.node;
          cmd.flow_col = prev_q.node;
          cmd.flow_bit = 1'b0;
        end
        prev_d = stk_rdata;
        if (k_q + ucmf_pkg::POS_W'(1) < depth_q) begin
          k_d       = k_q + ucmf_pkg::POS_W'(1);
          stk_raddr = k_d[ucmf_pkg::NODE_W-1:0];
        end else begin
          if (total_q != FLOW_MAX) total_d = total_q + ucmf_pkg::FLOW_W'(1);
          state_d = S_INIT;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLRCAP;
      sink_q  <= ucmf_pkg::NODE_W'(1);
      row_q   <= '0;
      vis_q   <= '0;
      depth_q <= '0;
      k_q     <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      sink_q  <= sink_d;
      row_q   <= row_d;
      vis_q   <= vis_d;
      depth_q <= depth_d;
      k_q     <= k_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    prev_q <= prev_d;
  end

  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = (state_q == S_DONE);
  assign max_flow_o = total_q;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result strobe while idle");
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= FULL) else $error("stack overflow");
  a_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i == ucmf_pkg::KIND_COMPUTE) |=> busy_o && !done_o)
    else $error("compute not started");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result repeated");
endmodule
`default_nettype wire

@@ rtl/ucmf_edge_mem.sv @@
// capacity, flow and transposed flow matrices with row clear
`default_nettype none
module ucmf_edge_mem (
  input  logic               clk_i,
  input  ucmf_pkg::mem_cmd_t cmd_i,
  output ucmf_pkg::mem_rd_t  rd_o
);
  logic [ucmf_pkg::NODES-1:0] cap_mem   [ucmf_pkg::NODES];
  logic [ucmf_pkg::NODES-1:0] flow_mem  [ucmf_pkg::NODES];
  logic [ucmf_pkg::NODES-1:0] flowt_mem [ucmf_pkg::NODES];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_clr) begin
      cap_mem[cmd_i.cap_row] <= '0;
    end else if (cmd_i.cap_we) begin
      cap_mem[cmd_i.cap_row][cmd_i.cap_col] <= cmd_i.cap_bit;
    end
    rd_o.cap <= cap_mem[cmd_i.rd_row][cmd_i.rd_col];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.flow_clr) begin
      flow_mem[cmd_i.flow_row] <= '0;
    end else if (cmd_i.flow_we) begin
      flow_mem[cmd_i.flow_row][cmd_i.flow_col] <= cmd_i.flow_bit;
    end
    rd_o.flow <= flow_mem[cmd_i.rd_row][cmd_i.rd_col];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.flow_clr) begin
      flowt_mem[cmd_i.flow_row] <= '0;
    end else if (cmd_i.flow_we) begin
      flowt_mem[cmd_i.flow_col][cmd_i.flow_row] <= cmd_i.flow_bit;
    end
    rd_o.flow_back <= flowt_mem[cmd_i.rd_row][cmd_i.rd_col];
  end
endmodule
`default_nettype wire

@@ rtl/ucmf_stack.sv @@
// search stack memory, one write and one registered read per cycle
`default_nettype none
module ucmf_stack (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [ucmf_pkg::NODE_W-1:0]   waddr_i,
  input  ucmf_pkg::stk_t                wdata_i,
  input  logic [ucmf_pkg::NODE_W-1:0]   raddr_i,
  output ucmf_pkg::stk_t                rdata_o
);
  ucmf_pkg::stk_t mem [ucmf_pkg::NODES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ bench/unit_capacity_max_flow_test.sv @@
// testbench for unit_capacity_max_flow: directed and random graphs against a predictor
`timescale 1ns / 1ps
module unit_capacity_max_flow_test;
  localparam logic [1:0] KIND_NONE = 2'd3;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start_i = 1'b0;
  logic                        busy_o;
  logic [1:0]                  kind_i = ucmf_pkg::KIND_EDGE;
  logic [ucmf_pkg::NODE_W-1:0] from_node_i = '0;
  logic [ucmf_pkg::NODE_W-1:0] to_node_i = '0;
  logic                        edge_present_i = 1'b0;
  logic                        sink_index_we_i = 1'b0;
  logic [ucmf_pkg::NODE_W-1:0] sink_index_i = '0;
  logic                        done_o;
  logic [ucmf_pkg::FLOW_W-1:0] max_flow_o;

  bit                          cap_m [ucmf_pkg::NODES][ucmf_pkg::NODES];
  bit                          flow_m [ucmf_pkg::NODES][ucmf_pkg::NODES];
  int unsigned                 sink_cfg = 1;
  logic [ucmf_pkg::FLOW_W-1:0] flow_expect [$];
  int                          mismatches = 0;
  bit                          no_idle = 0;

  unit_capacity_max_flow dut (.*);

  always #5 clk_i = ~clk_i;

  // one depth-first augmenting search, applies one unit when a path is found
  function automatic bit augment_path(int snk);
    bit seen [ucmf_pkg::NODES];
    int nd [ucmf_pkg::NODES];
    int ps [ucmf_pkg::NODES];
    bit ph [ucmf_pkg::NODES];
    bit dr [ucmf_pkg::NODES];
    int depth, t, u, i;
    seen[0] = 1;
    depth = 1;
    while (1) begin
      t = depth - 1;
      u = nd[t];
      i = ps[t];
      if (u == snk) break;
      if (i > snk) begin
        depth--;
        if (depth == 0) return 0;
        continue;
      end
      if (!ph[t]) begin
        if (seen[i]) begin
          ps[t] = i + 1;
          continue;
        end
        ph[t] = 1;
        if (cap_m[u][i] && !flow_m[u][i]) begin
          seen[i] = 1;
          dr[t] = 0;
          if (depth < ucmf_pkg::NODES) begin
            nd[depth] = i; ps[depth] = 0; ph[depth] = 0; dr[depth] = 0;
            depth++;
          end
        end
      end else begin
        ph[t] = 0;
        ps[t] = i + 1;
        if (flow_m[i][u]) begin
          seen[i] = 1;
          dr[t] = 1;
          if (depth < ucmf_pkg::NODES) begin
            nd[depth] = i; ps[depth] = 0; ph[depth] = 0; dr[depth] = 0;
            depth++;
          end
        end
      end
    end
    for (int k = 0; k + 1 < depth; k++) begin
      if (!dr[k]) flow_m[nd[k]][nd[k+1]] = 1;
      else flow_m[nd[k+1]][nd[k]] = 0;
    end
    return 1;
  endfunction

  task automatic predict_word(logic [1:0] kind, int fn, int tn, bit pres);
    int total;
    case (kind)
      ucmf_pkg::KIND_EDGE: cap_m[fn][tn] = pres;
      ucmf_pkg::KIND_CLEAR: begin
        foreach (cap_m[a, b]) cap_m[a][b] = 0;
      end
      ucmf_pkg::KIND_COMPUTE: begin
        foreach (flow_m[a, b]) flow_m[a][b] = 0;
        total = 0;
        if (sink_cfg != 0) begin
          while (augment_path(sink_cfg)) if (total < 127) total++;
        end
        flow_expect.push_back(ucmf_pkg::FLOW_W'(total));
      end
      default: ;
    endcase
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      if (flow_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word max_flow=%0d", max_flow_o);
      end else begin
        logic [ucmf_pkg::FLOW_W-1:0] want;
        want = flow_expect.pop_front();
        if (max_flow_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("max_flow mismatch: expected %0d actual %0d", want, max_flow_o);
        end
      end
    end
  end

  // call at a rising edge; returns at the edge that accepts the word
  task automatic send_word(logic [1:0] kind, int fn, int tn, bit pres);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    kind_i <= kind;
    from_node_i <= ucmf_pkg::NODE_W'(fn);
    to_node_i <= ucmf_pkg::NODE_W'(tn);
    edge_present_i <= pres;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    predict_word(kind, fn, tn, pres);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (flow_expect.size() != 0 || busy_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_sink(int v);
    wait_idle();
    sink_index_we_i <= 1'b1;
    sink_index_i <= ucmf_pkg::NODE_W'(v);
    @(posedge clk_i);
    sink_index_we_i <= 1'b0;
    sink_cfg = v;
  endtask

  task automatic test_basics();
    send_word(ucmf_pkg::KIND_COMPUTE, 0, 0, 0);
    send_word(ucmf_pkg::KIND_EDGE, 0, 1, 1);
    send_word(ucmf_pkg::KIND_COMPUTE, 0, 0, 0);
    send_word(KIND_NONE, 127, 127, 1);
    send_word(ucmf_pkg::KIND_COMPUTE, 0, 0, 0);
    send_word(ucmf_pkg::KIND_EDGE, 0, 1, 0);
    send_word(ucmf_pkg::KIND_COMPUTE, 0, 0, 0);
    send_word(ucmf_pkg::KIND_EDGE, 127, 127, 1);
    send_word(ucmf_pkg::KIND_EDGE, 0, 1, 1);
    send_word(ucmf_pkg::KIND_CLEAR, 0, 0, 0);
    send_word(ucmf_pkg::KIND_COMPUTE, 0, 0, 0);
    set_sink(0);
    send_word(ucmf_pkg::KIND_EDGE, 0, 0, 1);
    send_word(ucmf_pkg::KIND_COMPUTE, 0, 0, 0);
  endtask

  task automatic test_backward_edges();
    set_sink(3);
    no_idle = 1;
    send_word(ucmf_pkg::KIND_CLEAR, 0, 0, 0);
    send_word(ucmf_pkg::KIND_EDGE, 0, 1, 1);
    send_word(ucmf_pkg::KIND_EDGE, 1, 2, 1);
    send_word(ucmf_pkg::KIND_EDGE, 2, 3, 1);
    send_word(ucmf_pkg::KIND_EDGE, 0, 2, 1);
    send_word(ucmf_pkg::KIND_EDGE, 1, 3, 1);
    no_idle = 0;
    send_word(ucmf_pkg::KIND_COMPUTE, 0, 0, 0);
    send_word(ucmf_pkg::KIND_COMPUTE, 0, 0, 0);
  endtask

  task automatic test_wide_sink();
    set_sink(127);
    send_word(ucmf_pkg::KIND_CLEAR, 0, 0, 0);
    send_word(ucmf_pkg::KIND_COMPUTE, 0, 0, 0);
    send_word(ucmf_pkg::KIND_EDGE, 0, 127, 1);
    send_word(ucmf_pkg::KIND_EDGE, 0, 5, 1);
    send_word(ucmf_pkg::KIND_EDGE, 5, 127, 1);
    send_word(ucmf_pkg::KIND_EDGE, 0, 126, 1);
    send_word(ucmf_pkg::KIND_COMPUTE, 0, 0, 0);
  endtask

  task automatic test_random_graphs();
    int snk, r;
    for (int p = 0; p < 15; p++) begin
      snk = (p % 5 == 4) ? $urandom_range(0, 1) : $urandom_range(2, 10);
      set_sink(snk);
      no_idle = (p % 4 == 1);
      send_word(ucmf_pkg::KIND_CLEAR, 0, 0, 0);
      for (int n = 0; n < 110; n++) begin
        r = $urandom_range(0, 99);
        if (r < 8) send_word(ucmf_pkg::KIND_COMPUTE, $urandom, $urandom, $urandom);
        else if (r < 10) send_word(KIND_NONE, $urandom, $urandom, $urandom);
        else if (r < 11) send_word(ucmf_pkg::KIND_CLEAR, $urandom, $urandom, $urandom);
        else if (r < 20) send_word(ucmf_pkg::KIND_EDGE, $urandom_range(0, 127),
                                   $urandom_range(0, 127), $urandom);
        else send_word(ucmf_pkg::KIND_EDGE, $urandom_range(0, snk),
                       $urandom_range(0, snk), $urandom_range(0, 3) != 0);
      end
      send_word(ucmf_pkg::KIND_COMPUTE, 0, 0, 0);
      if (p == 7) wait_idle();
    end
    no_idle = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basics();
    test_backward_edges();
    test_wide_sink();
    test_random_graphs();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && flow_expect.size() == 0) begin
      $display("PASS unit_capacity_max_flow");
    end else begin
      $display("FAIL unit_capacity_max_flow");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("FAIL unit_capacity_max_flow");
    $finish;
  end
endmodule

@@ unit_capacity_max_flow.f @@
rtl/ucmf_pkg.sv
rtl/ucmf_edge_mem.sv
rtl/ucmf_stack.sv
rtl/unit_capacity_max_flow.sv
bench/unit_capacity_max_flow_test.sv
